/* rtl/two_tier_track_allocator_macros.svh */
// Assertion macros for the two-tier track allocator.
`ifndef TWO_TIER_TRACK_ALLOCATOR_MACROS_SVH
`define TWO_TIER_TRACK_ALLOCATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define TTA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TTA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TTA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TTA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/tta_pkg.sv */
// Shared constants and types for the two-tier track allocator.
package tta_pkg;
  localparam int Slots = 320;
  localparam int SlotW = 9;
  localparam int EntW = 36;
  localparam logic [3:0] OC_NEW_BOT = 4'd0, OC_NEW_TOP = 4'd1, OC_BOT_OW = 4'd2,
    OC_BOT_RMW = 4'd3, OC_TOP_OW = 4'd4, OC_DROP = 4'd5, OC_RD_TOP = 4'd6,
    OC_RD_BOT = 4'd7, OC_RD_MISS = 4'd8;
  localparam logic [1:0] OP_WR = 2'd0, OP_RD = 2'd1, OP_CLR = 2'd2;
  localparam logic [31:0] AmpBase = 32'd30720;
  localparam logic [47:0] Max48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [27:0] Max28 = 28'hFFF_FFFF;

  typedef struct packed {
    logic        start;
    logic [16:0] span;
  } sqrt_req_t;
endpackage

/* rtl/tta_ram.sv */
// Generic single-port synchronous RAM with registered read.
module tta_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* rtl/tta_sqrt.sv */
// Bit-serial integer square root of 2*d*2^16, one result bit per cycle.
module tta_sqrt import tta_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  sqrt_req_t       req,
  output logic            done,
  output logic [16:0]     root
);
  logic [33:0] rem_r, rem_nxt;
  logic [16:0] res_r, res_nxt;
  logic [35:0] x_r, x_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_nxt;
  logic [35:0] trial;

  always_comb begin
    rem_nxt = rem_r; res_nxt = res_r; x_nxt = x_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r, x_r[35:34]} - {17'd0, res_r, 2'b01};
    if (req.start) begin
      x_nxt = {2'b00, req.span, 17'd0};
      rem_nxt = '0; res_nxt = '0; cnt_nxt = 5'd18; busy_nxt = 1'b1;
    end else if (busy_r) begin
      x_nxt = {x_r[33:0], 2'b00};
      if (!trial[35]) begin
        rem_nxt = trial[33:0];
        res_nxt = {res_r[15:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], x_r[35:34]};
        res_nxt = {res_r[15:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done <= done_nxt; cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt; res_r <= res_nxt; x_r <= x_nxt;
  end
  assign root = res_r;
endmodule

/* rtl/two_tier_track_allocator.sv */
// Top level of the two-tier track allocator.
// Flow: write/read run two tag scans over the RAMs (bottom tier, then top tier), a decide
//   state and the 18-step bit-serial square root; op 2/3 go straight to the output.
// Throughput: one transaction at a time; a new one is taken only after the result is accepted.
// Reset (rst_n, synchronous): fill counts, heads and sums clear,
//   amplification sum to 30720; tag RAMs are not cleared.
`include "two_tier_track_allocator_macros.svh"
module two_tier_track_allocator import tta_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // op[1:0], table_level[5:2], table_key[37:6]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [239:0] out_tdata  // outcome, slot, step_latency, write/read totals,
                                  // top_overwrite_total, amplified_writes, dropped_total
);
  typedef enum logic [2:0] {S_IDLE, S_SCAN_B, S_SCAN_T, S_DECIDE, S_SQRT, S_OUT}
    state_t;
  state_t state_r;

  logic [1:0] op_r; logic [3:0] lvl_r; logic [31:0] key_r;
  logic [SlotW-1:0] idx_r, fill_b_r, fill_t_r, hit_b_r, hit_t_r;
  logic hb_r, ht_r, rd_vld_r;
  logic [15:0] wh_r; logic [13:0] rh_r;
  logic [47:0] wsum_r, rsum_r; logic [31:0] tov_r, amp_r, drop_r;
  logic [3:0] oc_r; logic [SlotW-1:0] slot_r; logic [27:0] lat_r;
  logic rmw_r, wr_bot_r, wr_top_r;

  logic [EntW-1:0] b_rd, t_rd;
  logic b_we, t_we;
  logic [SlotW-1:0] ram_addr;
  assign b_we = (state_r == S_DECIDE) && wr_bot_r;
  assign t_we = (state_r == S_DECIDE) && wr_top_r;
  assign ram_addr = (state_r == S_DECIDE) ? (wr_bot_r ? fill_b_r : fill_t_r) : idx_r;

  tta_ram #(.Width(EntW), .Depth(Slots)) u_bram (.clk(clk), .we(b_we),
    .addr(ram_addr), .wdata({lvl_r, key_r}), .rdata(b_rd));
  tta_ram #(.Width(EntW), .Depth(Slots)) u_tram (.clk(clk), .we(t_we),
    .addr(ram_addr), .wdata({lvl_r, key_r}), .rdata(t_rd));

  sqrt_req_t sreq; logic sdone; logic [16:0] sroot;
  tta_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .req(sreq), .done(sdone), .root(sroot));

  logic [SlotW-1:0] rd_idx_r;
  logic [13:0] pos14;
  logic [16:0] span17, from17, to17;
  logic [SlotW-1:0] tgt;
  logic [3:0] oc_d; logic rmw_d, wb_d, wt_d, chg_d;
  logic [44:0] prod;
  logic [31:0] seek;
  logic [37:0] wlat;
  logic [27:0] lat_s;

  // slots fill in order, so an entry is valid exactly when its index is below the fill count
  always_comb begin
    oc_d = OC_DROP; tgt = '0; rmw_d = 1'b0; wb_d = 1'b0; wt_d = 1'b0; chg_d = 1'b1;
    if (op_r == OP_WR) begin
      if (hb_r) begin
        tgt = hit_b_r; rmw_d = (hit_b_r < fill_t_r); oc_d = rmw_d ? OC_BOT_RMW : OC_BOT_OW;
      end else if (ht_r) begin
        tgt = hit_t_r; oc_d = OC_TOP_OW;
      end else if (fill_b_r < SlotW'(Slots)) begin
        tgt = fill_b_r; oc_d = OC_NEW_BOT; wb_d = 1'b1;
      end else if (fill_t_r < SlotW'(Slots)) begin
        tgt = fill_t_r; oc_d = OC_NEW_TOP; wt_d = 1'b1;
      end else begin
        chg_d = 1'b0;
      end
    end else begin
      tgt = ht_r ? hit_t_r : (hb_r ? hit_b_r : '0);
      oc_d = ht_r ? OC_RD_TOP : (hb_r ? OC_RD_BOT : OC_RD_MISS);
    end
    from17 = (op_r == OP_WR) ? {1'b0, wh_r} : {3'b000, rh_r};
    to17 = {3'b000, tgt, 5'd0};
    span17 = (from17 > to17) ? from17 - to17 : to17 - from17;
    sreq.start = (state_r == S_DECIDE) && chg_d && (op_r == OP_WR || op_r == OP_RD);
    sreq.span = span17;
    pos14 = {slot_r, 5'd0};
    prod = 45'(sroot) * 45'd8243;
    seek = prod[39:8] + 32'd131072;
    wlat = {1'b0, seek, 5'd0} + (rmw_r ? 38'(3932160 * 32) : 38'(327680 * 32));
    if (op_r == OP_RD) lat_s = (seek > 32'(Max28)) ? Max28 : seek[27:0];
    else lat_s = (wlat > 38'(Max28)) ? Max28 : wlat[27:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; in_tready <= 1'b0; out_tvalid <= 1'b0;
      fill_b_r <= '0; fill_t_r <= '0;
      wh_r <= '0; rh_r <= '0; wsum_r <= '0; rsum_r <= '0;
      tov_r <= '0; amp_r <= AmpBase; drop_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            in_tready <= 1'b0;
            op_r <= in_tdata[1:0]; lvl_r <= in_tdata[5:2]; key_r <= in_tdata[37:6];
            idx_r <= '0; rd_vld_r <= 1'b0; hb_r <= 1'b0; ht_r <= 1'b0;
            hit_b_r <= '0; hit_t_r <= '0;
            oc_r <= OC_NEW_BOT; slot_r <= '0; lat_r <= '0;
            if (in_tdata[1:0] == OP_WR || in_tdata[1:0] == OP_RD) begin
              state_r <= S_SCAN_B;
            end else begin
              if (in_tdata[1:0] == OP_CLR) begin
                wsum_r <= '0; tov_r <= '0; amp_r <= AmpBase;
              end
              state_r <= S_OUT; out_tvalid <= 1'b1;
            end
          end else begin
            in_tready <= 1'b1;
          end
        end
        S_SCAN_B, S_SCAN_T: begin
          rd_vld_r <= (idx_r < SlotW'(Slots));
          rd_idx_r <= idx_r;
          if (rd_vld_r) begin
            if (state_r == S_SCAN_B && !hb_r && (rd_idx_r < fill_b_r)
                && b_rd == {lvl_r, key_r}) begin
              hb_r <= 1'b1; hit_b_r <= rd_idx_r;
            end
            if (state_r == S_SCAN_T && !ht_r && (rd_idx_r < fill_t_r)
                && t_rd == {lvl_r, key_r}) begin
              ht_r <= 1'b1; hit_t_r <= rd_idx_r;
            end
          end
          if (idx_r < SlotW'(Slots)) begin
            idx_r <= idx_r + SlotW'(1);
          end else if (!rd_vld_r) begin
            idx_r <= '0;
            state_r <= (state_r == S_SCAN_B) ? S_SCAN_T : S_DECIDE;
          end
        end
        S_DECIDE: begin
          oc_r <= oc_d; slot_r <= tgt; rmw_r <= rmw_d;
          if (op_r == OP_WR && hb_r) ht_r <= 1'b0;
          if (wb_d) fill_b_r <= fill_b_r + SlotW'(1);
          if (wt_d) fill_t_r <= fill_t_r + SlotW'(1);
          if (!chg_d) begin
            drop_r <= (drop_r == '1) ? drop_r : drop_r + 32'd1;
            state_r <= S_OUT; out_tvalid <= 1'b1;
          end else begin
            if (rmw_d) begin
              tov_r <= (tov_r > 32'hFFFF_FFDF) ? '1 : tov_r + 32'd32;
              amp_r <= (amp_r > 32'hFFFF_FFBF) ? '1 : amp_r + 32'd64;
            end
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sdone) begin
            lat_r <= lat_s;
            if (op_r == OP_RD) begin
              rsum_r <= ((Max48 - rsum_r) < 48'(lat_s)) ? Max48 : rsum_r + 48'(lat_s);
              rh_r <= pos14 + 14'd31;
            end else begin
              wsum_r <= ((Max48 - wsum_r) < 48'(lat_s)) ? Max48 : wsum_r + 48'(lat_s);
              if (oc_r == OC_NEW_BOT || oc_r == OC_NEW_TOP)
                wh_r <= wh_r + ((slot_r == '0) ? 16'd31 : 16'd32);
              else
                wh_r <= {2'b00, pos14} + 16'd31;
            end
            state_r <= S_OUT; out_tvalid <= 1'b1;
          end
        end
        S_OUT: begin
          if (out_tready) begin
            out_tvalid <= 1'b0; state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // write-path register for the RAM write strobe in DECIDE
  always_ff @(posedge clk) begin
    if (state_r != S_DECIDE) begin
      wr_bot_r <= (state_r == S_SCAN_T) && (op_r == OP_WR) && !hb_r && !ht_r
                  && (fill_b_r < SlotW'(Slots));
      wr_top_r <= (state_r == S_SCAN_T) && (op_r == OP_WR) && !hb_r && !ht_r
                  && !(fill_b_r < SlotW'(Slots)) && (fill_t_r < SlotW'(Slots));
    end
  end

  assign out_tdata = {7'd0, drop_r, amp_r, tov_r, rsum_r, wsum_r, lat_r, slot_r, oc_r};

  `TTA_ASSERT_IMP(a_excl, clk, rst_n, 1'b1, !(in_tready && out_tvalid))
  `TTA_ASSERT_IMP(a_fill, clk, rst_n, 1'b1, fill_b_r <= SlotW'(Slots) && fill_t_r <= SlotW'(Slots))
  `TTA_ASSERT_NXT(a_drop, clk, rst_n, state_r == S_DECIDE && !chg_d, state_r == S_OUT)
endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the two-tier track allocator.
module tb_top;
  import tta_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int RAND_ITEMS = 840;
  localparam int LIMIT = 3000000;
  localparam int DRAIN = 2 * Slots + 60;

  typedef struct {
    logic [3:0]  outcome;
    logic [8:0]  slot;
    logic [27:0] lat;
    logic [47:0] wsum;
    logic [47:0] rsum;
    logic [31:0] tow;
    logic [31:0] amp;
    logic [31:0] drop;
  } alloc_res_t;

  typedef struct {
    logic [1:0]  op;
    logic [3:0]  lvl;
    logic [31:0] key;
    bit          typed;
    logic [3:0]  outcome;
    logic [8:0]  slot;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [39:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [239:0] out_tdata;

  two_tier_track_allocator u_top (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow of the allocator
  logic [31:0] bot_key [Slots];
  logic [3:0]  bot_lvl [Slots];
  bit          bot_vld [Slots];
  logic [31:0] top_key [Slots];
  logic [3:0]  top_lvl [Slots];
  bit          top_vld [Slots];
  int unsigned bot_fill, top_fill;
  logic [15:0] wr_head;
  logic [13:0] rd_head;
  logic [47:0] wr_sum, rd_sum;
  logic [31:0] tow_sum, amp_sum, drop_sum;

  alloc_res_t pending_results[$];
  logic [35:0] known_tables[$];
  int errors = 0;
  int received = 0;
  int cycles = 0;

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] seek_cost(logic [31:0] from, logic [31:0] to);
    logic [63:0] d, r;
    d = (from > to) ? 64'(from - to) : 64'(to - from);
    r = int_sqrt((2 * d) << 16);
    return ((r * 64'd8243) >> 8) + 64'd131072;
  endfunction

  function automatic logic [47:0] add_sat48(logic [47:0] a, logic [63:0] b);
    logic [63:0] s;
    s = 64'(a) + b;
    return (s > 64'(Max48)) ? Max48 : s[47:0];
  endfunction

  function automatic logic [31:0] add_sat32(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = a + b;
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic int find_entry(bit tier_top, logic [3:0] lvl, logic [31:0] key);
    for (int i = 0; i < Slots; i++) begin
      if (tier_top ? (top_vld[i] && top_key[i] == key && top_lvl[i] == lvl)
                   : (bot_vld[i] && bot_key[i] == key && bot_lvl[i] == lvl))
        return i;
    end
    return -1;
  endfunction

  task automatic reset_shadow();
    for (int i = 0; i < Slots; i++) begin
      bot_vld[i] = 0;
      top_vld[i] = 0;
    end
    bot_fill = 0;
    top_fill = 0;
    wr_head = 0;
    rd_head = 0;
    wr_sum = 0;
    rd_sum = 0;
    tow_sum = 0;
    amp_sum = AmpBase;
    drop_sum = 0;
  endtask

  function automatic alloc_res_t place_table(logic [1:0] op, logic [3:0] lvl,
                                             logic [31:0] key);
    alloc_res_t r;
    int hit;
    logic [31:0] pos;
    logic [63:0] lat;
    bit rmw;
    r.outcome = OC_NEW_BOT;
    r.slot = 0;
    lat = 0;
    if (op == OP_WR) begin
      hit = find_entry(0, lvl, key);
      if (hit >= 0) begin
        pos = hit * 32;
        rmw = top_vld[hit];
        if (rmw) begin
          tow_sum = add_sat32(tow_sum, 32);
          amp_sum = add_sat32(amp_sum, 64);
        end
        lat = 32 * (seek_cost(32'(wr_head), pos) + (rmw ? 64'd3932160 : 64'd327680));
        wr_head = 16'(pos + 31);
        r.outcome = rmw ? OC_BOT_RMW : OC_BOT_OW;
        r.slot = 9'(hit);
      end else if ((hit = find_entry(1, lvl, key)) >= 0) begin
        pos = hit * 32;
        lat = 32 * (seek_cost(32'(wr_head), pos) + 64'd327680);
        wr_head = 16'(pos + 31);
        r.outcome = OC_TOP_OW;
        r.slot = 9'(hit);
      end else if (bot_fill < Slots) begin
        r.slot = 9'(bot_fill);
        bot_key[bot_fill] = key;
        bot_lvl[bot_fill] = lvl;
        bot_vld[bot_fill] = 1;
        lat = 32 * (seek_cost(32'(wr_head), bot_fill * 32) + 64'd327680);
        wr_head = wr_head + ((bot_fill == 0) ? 16'd31 : 16'd32);
        bot_fill++;
        r.outcome = OC_NEW_BOT;
      end else if (top_fill < Slots) begin
        r.slot = 9'(top_fill);
        top_key[top_fill] = key;
        top_lvl[top_fill] = lvl;
        top_vld[top_fill] = 1;
        lat = 32 * (seek_cost(32'(wr_head), top_fill * 32) + 64'd327680);
        wr_head = wr_head + ((top_fill == 0) ? 16'd31 : 16'd32);
        top_fill++;
        r.outcome = OC_NEW_TOP;
      end else begin
        drop_sum = add_sat32(drop_sum, 1);
        r.outcome = OC_DROP;
      end
      if (lat > 64'(Max28)) lat = 64'(Max28);
      wr_sum = add_sat48(wr_sum, lat);
    end else if (op == OP_RD) begin
      hit = find_entry(1, lvl, key);
      if (hit >= 0) begin
        r.outcome = OC_RD_TOP;
      end else begin
        hit = find_entry(0, lvl, key);
        r.outcome = (hit >= 0) ? OC_RD_BOT : OC_RD_MISS;
      end
      r.slot = (hit >= 0) ? 9'(hit) : 9'd0;
      pos = r.slot * 32;
      lat = seek_cost(32'(rd_head), pos);
      if (lat > 64'(Max28)) lat = 64'(Max28);
      rd_sum = add_sat48(rd_sum, lat);
      rd_head = 14'(pos + 31);
    end else if (op == OP_CLR) begin
      wr_sum = 0;
      tow_sum = 0;
      amp_sum = AmpBase;
    end
    r.lat = lat[27:0];
    r.wsum = wr_sum;
    r.rsum = rd_sum;
    r.tow = tow_sum;
    r.amp = amp_sum;
    r.drop = drop_sum;
    return r;
  endfunction

  // sender
  int send_gap_max = 4;
  bit sent_all = 0;

  task automatic send_table(logic [1:0] op, logic [3:0] lvl, logic [31:0] key,
                            output alloc_res_t r);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, key, lvl, op};
    do @(posedge clk); while (!in_tready);
    r = place_table(op, lvl, key);
    pending_results.push_back(r);
    if (op == OP_WR) known_tables.push_back({lvl, key});
  endtask

  dir_row_t dir_rows[] = '{
    '{OP_RD,   4'd0,  32'h0,         1, OC_RD_MISS, 9'd0},
    '{OP_NONE, 4'd15, 32'hFFFF_FFFF, 1, OC_NEW_BOT, 9'd0},
    '{OP_CLR,  4'd0,  32'h0,         1, OC_NEW_BOT, 9'd0},
    '{OP_WR,   4'd0,  32'h0,         1, OC_NEW_BOT, 9'd0},
    '{OP_WR,   4'd15, 32'hFFFF_FFFF, 1, OC_NEW_BOT, 9'd1},
    '{OP_WR,   4'd0,  32'h0,         1, OC_BOT_OW,  9'd0},
    '{OP_RD,   4'd15, 32'hFFFF_FFFF, 1, OC_RD_BOT,  9'd1},
    '{OP_RD,   4'd15, 32'h0,         1, OC_RD_MISS, 9'd0},
    '{OP_WR,   4'd15, 32'h0,         1, OC_NEW_BOT, 9'd2},
    '{OP_WR,   4'd5,  32'hA5A5_A5A5, 0, OC_NEW_BOT, 9'd0},
    '{OP_WR,   4'd10, 32'h5A5A_5A5A, 0, OC_NEW_BOT, 9'd0},
    '{OP_RD,   4'd0,  32'h0,         1, OC_RD_BOT,  9'd0},
    '{OP_WR,   4'd15, 32'hFFFF_FFFF, 0, OC_NEW_BOT, 9'd0},
    '{OP_RD,   4'd10, 32'h5A5A_5A5A, 0, OC_NEW_BOT, 9'd0},
    '{OP_CLR,  4'd0,  32'h0,         0, OC_NEW_BOT, 9'd0}
  };

  initial begin
    alloc_res_t r;
    int pick, mode;
    logic [1:0] op;
    logic [3:0] lvl;
    logic [31:0] key;
    logic [35:0] t;
    reset_shadow();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      send_table(dir_rows[i].op, dir_rows[i].lvl, dir_rows[i].key, r);
      if (dir_rows[i].typed && (r.outcome != dir_rows[i].outcome ||
                                r.slot != dir_rows[i].slot)) begin
        $error("directed row %0d: outcome exp %0d got %0d, slot exp %0d got %0d",
               i, dir_rows[i].outcome, r.outcome, dir_rows[i].slot, r.slot);
        errors++;
      end
    end
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 60 == 0) send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 4;
      if (n == 400) begin
        in_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      lvl = 4'($urandom_range(0, 15));
      key = $urandom;
      if (pick < 80) begin
        op = OP_WR;
      end else if (pick < 88) begin
        op = OP_WR;
        t = known_tables[$urandom_range(0, known_tables.size() - 1)];
        {lvl, key} = t;
      end else if (pick < 96) begin
        op = OP_RD;
        mode = $urandom_range(0, 9);
        if (mode < 7) begin
          t = known_tables[$urandom_range(0, known_tables.size() - 1)];
          {lvl, key} = t;
        end
      end else begin
        op = (pick < 98) ? OP_CLR : OP_NONE;
      end
      send_table(op, lvl, key, r);
    end
    in_tvalid <= 1'b0;
    sent_all = 1;
  end

  // result side
  int recv_gap_max = 4;

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, got_v);
      errors++;
    end
  endtask

  initial begin
    alloc_res_t e;
    int gap;
    forever begin
      if (received == 100) begin
        out_tready <= 1'b0;
        repeat (3000) @(posedge clk);
      end
      if (received % 50 == 0) recv_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 4;
      gap = $urandom_range(0, recv_gap_max);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      received++;
      if (pending_results.size() == 0) begin
        $error("transaction out with no result pending");
        errors++;
      end else begin
        e = pending_results.pop_front();
        check_field("outcome", 64'(e.outcome), 64'(out_tdata[3:0]));
        check_field("slot", 64'(e.slot), 64'(out_tdata[12:4]));
        check_field("step_latency", 64'(e.lat), 64'(out_tdata[40:13]));
        check_field("write_latency_total", 64'(e.wsum), 64'(out_tdata[88:41]));
        check_field("read_lat_total", 64'(e.rsum), 64'(out_tdata[136:89]));
        check_field("top_overwrite_total", 64'(e.tow), 64'(out_tdata[168:137]));
        check_field("amplified_writes", 64'(e.amp), 64'(out_tdata[200:169]));
        check_field("dropped_total", 64'(e.drop), 64'(out_tdata[232:201]));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    wait (sent_all);
    wait (pending_results.size() == 0);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule
